// ===== sv/scpd_pkg.sv =====
// Shared types, codes and constants of the serial command packet deframer.
package scpd_pkg;

  localparam int DATA_DEPTH_DEF = 32;
  localparam int MAX_DATA_OUT   = 32;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;

  // Register index, taken from paddr[2]
  localparam logic REG_OWN_ADDRESS = 1'b0;
  localparam logic REG_TIMEOUT     = 1'b1;

  localparam logic [7:0]  OWN_ADDRESS_RST = 8'd0;
  localparam logic [15:0] TIMEOUT_RST     = 16'd100;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_RESEND = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_HDR1 = 3'd0,
    PH_HDR2 = 3'd1,
    PH_ADDR = 3'd2,
    PH_CMD  = 3'd3,
    PH_LEN  = 3'd4,
    PH_DATA = 3'd5,
    PH_SUM  = 3'd6
  } phase_t;

  typedef enum logic {
    EM_IDLE = 1'b0,
    EM_RUN  = 1'b1
  } emit_t;

  typedef struct packed {
    logic hdr1;
    logic hdr2;
    logic len_zero;
    logic data_last;
    logic timed_out;
    logic sum_ok;
    logic addr_match;
    logic slot_free;
    logic load_last;
  } dp_status_t;

  typedef struct packed {
    logic cap_time;
    logic ld_addr;
    logic ld_cmd;
    logic ld_len;
    logic ld_data;
    logic start_ok;
    logic start_resend;
    logic load;
  } dp_cmd_t;

endpackage

// ===== sv/scpd_ctrl.sv =====
// Controller: frame parse state machine and result emission state machine.
module scpd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  scpd_pkg::dp_status_t st,
  output scpd_pkg::dp_cmd_t    cmd
);

  scpd_pkg::phase_t phase, phase_next, eff;
  scpd_pkg::emit_t  emit, emit_next;
  logic             in_fire;

  assign in_ready = (emit == scpd_pkg::EM_IDLE);
  assign in_fire  = in_valid && in_ready;
  // A timed-out frame restarts before the byte is parsed
  assign eff      = st.timed_out ? scpd_pkg::PH_HDR1 : phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= scpd_pkg::PH_HDR1;
      emit  <= scpd_pkg::EM_IDLE;
    end else begin
      phase <= phase_next;
      emit  <= emit_next;
    end
  end

  always_comb begin
    phase_next = phase;
    emit_next  = emit;
    if (in_fire) begin
      case (eff)
        scpd_pkg::PH_HDR1: phase_next = st.hdr1 ? scpd_pkg::PH_HDR2 : scpd_pkg::PH_HDR1;
        scpd_pkg::PH_HDR2: phase_next = st.hdr2 ? scpd_pkg::PH_ADDR : scpd_pkg::PH_HDR1;
        scpd_pkg::PH_ADDR: phase_next = scpd_pkg::PH_CMD;
        scpd_pkg::PH_CMD:  phase_next = scpd_pkg::PH_LEN;
        scpd_pkg::PH_LEN:  phase_next = st.len_zero ? scpd_pkg::PH_SUM : scpd_pkg::PH_DATA;
        scpd_pkg::PH_DATA: phase_next = st.data_last ? scpd_pkg::PH_SUM : scpd_pkg::PH_DATA;
        scpd_pkg::PH_SUM: begin
          phase_next = scpd_pkg::PH_HDR1;
          if (!st.sum_ok || st.addr_match) begin
            emit_next = scpd_pkg::EM_RUN;
          end
        end
        default: phase_next = scpd_pkg::PH_HDR1;
      endcase
    end
    if (emit == scpd_pkg::EM_RUN && st.slot_free && st.load_last) begin
      emit_next = scpd_pkg::EM_IDLE;
    end
  end

  always_comb begin
    cmd = '0;
    if (in_fire) begin
      case (eff)
        scpd_pkg::PH_HDR1: cmd.cap_time = st.hdr1;
        scpd_pkg::PH_ADDR: cmd.ld_addr  = 1'b1;
        scpd_pkg::PH_CMD:  cmd.ld_cmd   = 1'b1;
        scpd_pkg::PH_LEN:  cmd.ld_len   = 1'b1;
        scpd_pkg::PH_DATA: cmd.ld_data  = 1'b1;
        scpd_pkg::PH_SUM: begin
          cmd.start_ok     = st.sum_ok && st.addr_match;
          cmd.start_resend = !st.sum_ok;
        end
        default: cmd = '0;
      endcase
    end
    cmd.load = (emit == scpd_pkg::EM_RUN) && st.slot_free;
  end

endmodule

// ===== sv/scpd_dp.sv =====
// Datapath: config registers, packet fields, checksum, data store, result register.
module scpd_dp #(
  parameter int DATA_DEPTH = scpd_pkg::DATA_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic [7:0]           rx_byte,
  input  logic [31:0]          now_ms,
  input  scpd_pkg::dp_cmd_t    cmd,
  output scpd_pkg::dp_status_t st,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           kind,
  output logic [7:0]           command_code,
  output logic [7:0]           data_length,
  output logic [7:0]           data_byte,
  output logic [4:0]           byte_index,
  output logic                 truncated,
  output logic                 last
);

  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int LIMIT = (DATA_DEPTH < scpd_pkg::MAX_DATA_OUT) ?
                         DATA_DEPTH : scpd_pkg::MAX_DATA_OUT;
  localparam logic [7:0] DEPTH8 = 8'(DATA_DEPTH);
  localparam logic [7:0] LIMIT8 = 8'(LIMIT);

  logic [7:0]  own_address;
  logic [15:0] timeout_ms;
  logic [31:0] start_time;
  logic [7:0]  pkt_address, pkt_command, pkt_length, recv_count, running_sum;
  logic [7:0]  store [DATA_DEPTH];
  logic [7:0]  rdata;
  logic [5:0]  ptr, ptr_next, stored;
  logic        cmd_done, resend, trunc, wr_en;
  logic [31:0] elapsed;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = (paddr[2] == scpd_pkg::REG_TIMEOUT) ? {16'd0, timeout_ms} :
                                                        {24'd0, own_address};

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= scpd_pkg::OWN_ADDRESS_RST;
      timeout_ms  <= scpd_pkg::TIMEOUT_RST;
    end else if (wr_en) begin
      if (paddr[2] == scpd_pkg::REG_OWN_ADDRESS) begin
        own_address <= pwdata[7:0];
      end else begin
        timeout_ms <= pwdata[15:0];
      end
    end
  end

  assign elapsed = now_ms - start_time;
  assign trunc   = pkt_length > DEPTH8;
  assign stored  = (pkt_length > LIMIT8) ? 6'(LIMIT) : pkt_length[5:0];

  always_comb begin
    st.hdr1       = rx_byte == scpd_pkg::HDR_FIRST;
    st.hdr2       = rx_byte == scpd_pkg::HDR_SECOND;
    st.len_zero   = rx_byte == 8'd0;
    st.data_last  = 8'(recv_count + 8'd1) == pkt_length;
    st.timed_out  = elapsed >= {16'd0, timeout_ms};
    st.sum_ok     = rx_byte == running_sum;
    st.addr_match = pkt_address == own_address;
    st.slot_free  = !out_valid || out_ready;
    st.load_last  = resend || (!cmd_done ? (stored == 6'd0) : (6'(ptr + 6'd1) == stored));
  end

  // Frame fields and checksum
  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= 32'd0;
    end else if (cmd.cap_time) begin
      start_time <= now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_addr) begin
      pkt_address <= rx_byte;
      running_sum <= rx_byte;
    end
    if (cmd.ld_cmd || cmd.ld_len || cmd.ld_data) begin
      running_sum <= 8'(running_sum + rx_byte);
    end
    if (cmd.ld_cmd) begin
      pkt_command <= rx_byte;
    end
    if (cmd.ld_len) begin
      pkt_length <= rx_byte;
      recv_count <= 8'd0;
    end
    if (cmd.ld_data) begin
      recv_count <= 8'(recv_count + 8'd1);
    end
  end

  // Data store: one write port, one registered read port
  always_comb begin
    ptr_next = ptr;
    if (cmd.start_ok) begin
      ptr_next = 6'd0;
    end else if (cmd.load && cmd_done && !resend) begin
      ptr_next = 6'(ptr + 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_data && recv_count < DEPTH8) begin
      store[recv_count[AW-1:0]] <= rx_byte;
    end
    rdata <= store[ptr_next[AW-1:0]];
  end

  // Emission bookkeeping
  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (cmd.start_ok) begin
      cmd_done <= 1'b0;
      resend   <= 1'b0;
    end else if (cmd.start_resend) begin
      resend   <= 1'b1;
    end else if (cmd.load) begin
      cmd_done <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last <= st.load_last;
      if (resend) begin
        kind         <= scpd_pkg::KIND_RESEND;
        command_code <= 8'd0;
        data_length  <= 8'd0;
        data_byte    <= 8'd0;
        byte_index   <= 5'd0;
        truncated    <= 1'b0;
      end else begin
        command_code <= pkt_command;
        data_length  <= pkt_length;
        truncated    <= trunc;
        if (!cmd_done) begin
          kind       <= scpd_pkg::KIND_CMD;
          data_byte  <= 8'd0;
          byte_index <= 5'd0;
        end else begin
          kind       <= scpd_pkg::KIND_DATA;
          data_byte  <= rdata;
          byte_index <= ptr[4:0];
        end
      end
    end
  end

endmodule

// ===== sv/serial_command_packet_deframer.sv =====
// Top level of the serial command packet deframer.
// Usage:
//   Input channel (in_valid/in_ready, rx_byte, now_ms) takes one received byte per
//   transaction with its millisecond timestamp. Frames are 0xAA 0x55 address command
//   length data... checksum; a frame timeout_ms or more old restarts parsing.
//   Output channel (out_valid/out_ready) delivers results from a result register.
//   Configuration: APB-style port, own_address at 0x0, timeout_ms at 0x4.
// Result runs:
//   Header, field and data bytes are taken one per cycle while no result run is in
//   progress. The checksum byte of a good, addressed packet starts a run of
//   1 + min(length, DATA_DEPTH, 32) results, one per cycle while the result register
//   is free, paced by the single read port of the data store; a bad checksum gives one
//   resend result. The checksum transaction sets the emission state to EM_RUN, and from
//   there each result is loaded into the result register once it is free. in_ready
//   stays low until the last result of the run is loaded.
// Reset:
//   rst (synchronous) returns parsing to the first header byte, clears start_time,
//   sets own_address to 0 and timeout_ms to 100, and empties the result register.
// Stall:
//   While out_ready is low a full result register holds and the run waits; no result is
//   dropped, and the input stays blocked until the run has been loaded.
module serial_command_packet_deframer #(
  parameter int DATA_DEPTH = scpd_pkg::DATA_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  command_code,
  output logic [7:0]  data_length,
  output logic [7:0]  data_byte,
  output logic [4:0]  byte_index,
  output logic        truncated,
  output logic        last
);

  scpd_pkg::dp_status_t st;
  scpd_pkg::dp_cmd_t    cmd;

  // Parse and emission sequencing
  scpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Registers, checksum, data store and result register
  scpd_dp #(
    .DATA_DEPTH (DATA_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .rx_byte      (rx_byte),
    .now_ms       (now_ms),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .command_code (command_code),
    .data_length  (data_length),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .truncated    (truncated),
    .last         (last)
  );

  // A started run blocks the input on the next cycle
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.start_ok || cmd.start_resend) |=> !in_ready)
    else $error("input not blocked after a run started");

  // Loading the final result of a run reopens the input
  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && st.load_last) |=> in_ready)
    else $error("input still blocked after the last result was loaded");

  // A loaded result carries the last flag exactly when the run ends
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (out_valid && (last == $past(st.load_last))))
    else $error("last flag does not match end of run");

endmodule

// ===== dv/tb_serial_command_packet_deframer.sv =====
// Testbench for the serial command packet deframer: framed byte stream in, checked results out.
`timescale 1ns / 100ps

module tb_serial_command_packet_deframer;

  localparam int DEPTH  = scpd_pkg::DATA_DEPTH_DEF;
  localparam int SETTLE = 40;   // cycles for a silent checksum to clear the block

  // Byte addresses of the two registers: the index sits in paddr[2]
  localparam logic [2:0] ADDR_OWN = {scpd_pkg::REG_OWN_ADDRESS, 2'b00};
  localparam logic [2:0] ADDR_TMO = {scpd_pkg::REG_TIMEOUT, 2'b00};

  typedef struct {
    logic [7:0]  b;
    logic [31:0] stamp;
  } rx_beat_t;

  typedef struct packed {
    scpd_pkg::kind_t kind;
    logic [7:0]      cmd;
    logic [7:0]      len;
    logic [7:0]      dbyte;
    logic [4:0]      idx;
    logic            trunc;
    logic            last;
  } result_t;

  // DUT pins; every input the bench drives is known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = '0;
  logic [31:0] now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  command_code;
  logic [7:0]  data_length;
  logic [7:0]  data_byte;
  logic [4:0]  byte_index;
  logic        truncated;
  logic        last;

  // Byte stream waiting for the driver, and the results it must produce
  rx_beat_t rx_stream[$];
  result_t  deframed_q[$];

  int beats_total    = 0;   // beats pushed into rx_stream
  int beats_accepted = 0;   // beats taken by the block
  bit in_taken       = 1'b0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int fail_count     = 0;
  logic [31:0] now_val = '0;
  int dt_max = 1;

  // Parser copy: configuration and frame state
  logic [7:0]       cfg_own     = scpd_pkg::OWN_ADDRESS_RST;
  logic [15:0]      cfg_timeout = scpd_pkg::TIMEOUT_RST;
  scpd_pkg::phase_t ph          = scpd_pkg::PH_HDR1;
  logic [31:0]      t_start     = '0;
  logic [7:0]       p_addr      = '0;
  logic [7:0]       p_cmd       = '0;
  logic [7:0]       p_len       = '0;
  logic [7:0]       rcv_cnt     = '0;
  logic [7:0]       run_sum     = '0;
  logic [7:0]       rx_store [DEPTH];

  serial_command_packet_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .command_code (command_code),
    .data_length  (data_length),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .truncated    (truncated),
    .last         (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Parse one accepted byte and queue whatever results it produces.
  // The timeout test runs first, so a late 0xAA opens a fresh frame at once.
  task automatic deframe_byte(input logic [7:0] c, input logic [31:0] stamp);
    logic [31:0] elapsed;
    int          stored;
    logic        trunc;
    result_t     r;
    elapsed = stamp - t_start;
    if (elapsed >= {16'd0, cfg_timeout}) ph = scpd_pkg::PH_HDR1;
    case (ph)
      scpd_pkg::PH_HDR1: begin
        if (c == scpd_pkg::HDR_FIRST) begin
          t_start = stamp;
          ph      = scpd_pkg::PH_HDR2;
        end
      end
      // A wrong second header byte drops back without a second look at it
      scpd_pkg::PH_HDR2: begin
        ph = (c == scpd_pkg::HDR_SECOND) ? scpd_pkg::PH_ADDR : scpd_pkg::PH_HDR1;
      end
      scpd_pkg::PH_ADDR: begin
        p_addr  = c;
        run_sum = c;
        ph      = scpd_pkg::PH_CMD;
      end
      scpd_pkg::PH_CMD: begin
        p_cmd   = c;
        run_sum = run_sum + c;
        ph      = scpd_pkg::PH_LEN;
      end
      scpd_pkg::PH_LEN: begin
        p_len   = c;
        run_sum = run_sum + c;
        rcv_cnt = '0;
        ph      = (c == 8'd0) ? scpd_pkg::PH_SUM : scpd_pkg::PH_DATA;
      end
      scpd_pkg::PH_DATA: begin
        // Bytes past the store still feed the checksum
        if (rcv_cnt < DEPTH) rx_store[rcv_cnt] = c;
        rcv_cnt = rcv_cnt + 8'd1;
        run_sum = run_sum + c;
        if (rcv_cnt == p_len) ph = scpd_pkg::PH_SUM;
      end
      scpd_pkg::PH_SUM: begin
        if (c == run_sum) begin
          // Good frame for another address: stay silent
          if (p_addr == cfg_own) begin
            stored = p_len;
            if (stored > DEPTH) stored = DEPTH;
            if (stored > scpd_pkg::MAX_DATA_OUT) stored = scpd_pkg::MAX_DATA_OUT;
            trunc = (p_len > DEPTH);
            r = '{kind: scpd_pkg::KIND_CMD, cmd: p_cmd, len: p_len, dbyte: 8'd0,
                  idx: 5'd0, trunc: trunc, last: (stored == 0)};
            deframed_q.push_back(r);
            for (int i = 0; i < stored; i++) begin
              r = '{kind: scpd_pkg::KIND_DATA, cmd: p_cmd, len: p_len, dbyte: rx_store[i],
                    idx: 5'(i), trunc: trunc, last: (i + 1 == stored)};
              deframed_q.push_back(r);
            end
          end
        end else begin
          r = '{kind: scpd_pkg::KIND_RESEND, cmd: 8'd0, len: 8'd0, dbyte: 8'd0, idx: 5'd0,
                trunc: 1'b0, last: 1'b1};
          deframed_q.push_back(r);
        end
        ph = scpd_pkg::PH_HDR1;
      end
      default: ph = scpd_pkg::PH_HDR1;
    endcase
  endtask

  // Monitor: predict on every input transaction, check every output transaction
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        deframe_byte(rx_byte, now_ms);
        beats_accepted++;
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        got = '{kind: scpd_pkg::kind_t'(kind), cmd: command_code, len: data_length,
                dbyte: data_byte, idx: byte_index, trunc: truncated, last: last};
        if (deframed_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with none pending: kind=%0d cmd=%02h len=%0d",
                     $realtime, got.kind, got.cmd, got.len);
        end else begin
          want = deframed_q.pop_front();
          if (got.kind !== want.kind || got.cmd !== want.cmd || got.len !== want.len ||
              got.dbyte !== want.dbyte || got.idx !== want.idx ||
              got.trunc !== want.trunc || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch want kind=%0d cmd=%02h len=%0d byte=%02h idx=%0d ",
                        "trunc=%0b last=%0b / got kind=%0d cmd=%02h len=%0d byte=%02h ",
                        "idx=%0d trunc=%0b last=%0b"},
                       $realtime, want.kind, want.cmd, want.len, want.dbyte, want.idx,
                       want.trunc, want.last, got.kind, got.cmd, got.len, got.dbyte,
                       got.idx, got.trunc, got.last);
          end
        end
      end
    end
  end

  // Driver: hold the payload until taken, then load the next beat or idle
  always @(negedge clk) begin
    rx_beat_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (rx_stream.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = rx_stream.pop_front();
        in_valid <= 1'b1;
        rx_byte  <= nxt.b;
        now_ms   <= nxt.stamp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: a requested hold-off wins over the random stall
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Limit on the whole run
  initial begin
    #10_000_000;
    $display("tb_serial_command_packet_deframer: FAIL");
    $finish;
  end

  // Advance time by a small random step and queue one byte
  task automatic push_beat(input logic [7:0] b);
    rx_beat_t bt;
    now_val  = now_val + $urandom_range(0, dt_max);
    bt.b     = b;
    bt.stamp = now_val;
    rx_stream.push_back(bt);
    beats_total++;
  endtask

  // Queue a whole frame; extreme data alternates 0x00 and 0xFF
  task automatic push_frame(input logic [7:0] addr, input logic [7:0] cmd,
                            input logic [7:0] len, input bit bad_sum, input bit extreme);
    logic [7:0] sum;
    logic [7:0] d;
    sum = addr + cmd + len;
    push_beat(scpd_pkg::HDR_FIRST);
    push_beat(scpd_pkg::HDR_SECOND);
    push_beat(addr);
    push_beat(cmd);
    push_beat(len);
    for (int i = 0; i < len; i++) begin
      d = extreme ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
      sum = sum + d;
      push_beat(d);
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    push_beat(sum);
  endtask

  // Jump past the timeout so a dangling partial frame is dropped
  task automatic time_jump();
    now_val = now_val + cfg_timeout + $urandom_range(0, 3);
  endtask

  // Mostly well-formed frames with random content, the rest broken or noise
  task automatic push_random(input int count);
    int         first;
    int         r;
    int         n;
    logic [7:0] len;
    logic [7:0] b;
    first = beats_total;
    while (beats_total - first < count) begin
      r = $urandom_range(0, 99);
      n = $urandom_range(0, 99);
      len = (n < 80) ? 8'($urandom_range(0, 6)) :
            (n < 95) ? 8'($urandom_range(7, 31)) : 8'($urandom_range(32, 40));
      if (r < 65) begin
        push_frame(cfg_own, 8'($urandom_range(0, 255)), len, 1'b0, n < 5);
      end else if (r < 75) begin
        push_frame((n < 50) ? cfg_own : 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), len, 1'b1, 1'b0);
      end else if (r < 83) begin
        push_frame(cfg_own ^ 8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                   len, 1'b0, 1'b0);
      end else if (r < 90) begin
        // Line noise, then resync
        repeat ($urandom_range(1, 6)) push_beat(8'($urandom_range(0, 255)));
        time_jump();
      end else if (r < 95) begin
        // Second header byte corrupted
        b = 8'($urandom_range(0, 255));
        if (b == scpd_pkg::HDR_SECOND) b = ~b;
        push_beat(scpd_pkg::HDR_FIRST);
        push_beat(b);
      end else begin
        // Frame stalls mid-way; the next 0xAA arrives late and restarts parsing
        push_beat(scpd_pkg::HDR_FIRST);
        push_beat(scpd_pkg::HDR_SECOND);
        repeat ($urandom_range(0, 4)) push_beat(8'($urandom_range(0, 255)));
        time_jump();
        push_frame(cfg_own, 8'($urandom_range(0, 255)), len, 1'b0, 1'b0);
      end
    end
  endtask

  // Wait until every byte is in and every result out, then let the block settle
  task automatic wait_drained();
    do @(negedge clk); while (beats_accepted != beats_total || deframed_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write both registers and mirror them; only called with the block idle
  task automatic set_config(input logic [7:0] own, input logic [15:0] tmo);
    apb_write(ADDR_OWN, {24'd0, own});
    apb_write(ADDR_TMO, {16'd0, tmo});
    cfg_own     = own;
    cfg_timeout = tmo;
    dt_max      = (tmo >= 16'd100) ? 1 : 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset config, no idling, first byte stamped at 0 or 1 ms
    @(posedge clk);
    push_frame(8'h00, 8'hFF, 8'd2, 1'b0, 1'b1);    // command plus extreme data
    push_frame(8'h00, 8'h00, 8'd0, 1'b1, 1'b0);    // bad checksum: resend request
    push_frame(8'hFF, 8'h5A, 8'd0, 1'b0, 1'b0);    // other address: silent
    push_beat(scpd_pkg::HDR_FIRST);                // 0xAA where 0x55 belongs
    push_frame(8'h00, 8'h33, 8'd1, 1'b0, 1'b0);
    wait_drained();

    // Timeout of zero: every byte restarts the parser, so nothing comes out
    set_config(8'h00, 16'd0);
    @(posedge clk);
    push_frame(8'h00, 8'h00, 8'd0, 1'b0, 1'b0);
    wait_drained();

    // Top extremes; stamps start just below 2^32; one over-long frame; long hold-off
    set_config(8'hFF, 16'hFFFF);
    @(posedge clk);
    now_val = 32'hFFFF_FF00;
    push_frame(8'hFF, 8'($urandom_range(0, 255)), 8'd40, 1'b0, 1'b0);
    push_random(40);
    hold_left = 600;
    wait_drained();

    // Shortest useful timeout; sender mostly idle
    set_config(8'($urandom_range(1, 254)), 16'd1);
    @(posedge clk);
    send_idle_pct = 85;
    push_random(40);
    wait_drained();

    // Reset values again; receiver mostly stalled
    set_config(scpd_pkg::OWN_ADDRESS_RST, scpd_pkg::TIMEOUT_RST);
    @(posedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 85;
    push_random(40);
    wait_drained();

    // Random settings; both sides idle now and then
    set_config(8'($urandom_range(0, 255)), 16'($urandom_range(200, 65535)));
    @(posedge clk);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    push_random(40);
    wait_drained();

    if (fail_count == 0) begin
      $display("tb_serial_command_packet_deframer: PASS");
    end else begin
      $display("tb_serial_command_packet_deframer: FAIL");
    end
    $finish;
  end

endmodule
